@@ hdl/irs_pkg.sv @@
// ----------------------------------------------------------------------------
// irs_pkg - shared types and constants for the image resampler
// ----------------------------------------------------------------------------
package irs_pkg;

  localparam int CfgIdxW = 3;
  localparam int CfgDataW = 26;

  typedef enum logic [CfgIdxW-1:0] {
    REG_MODE       = 3'd0,
    REG_SRC_WIDTH  = 3'd1,
    REG_SRC_HEIGHT = 3'd2,
    REG_X_STEP     = 3'd3,
    REG_Y_STEP     = 3'd4
  } cfg_reg_t;

  localparam logic OP_WRITE   = 1'b0;
  localparam logic OP_COMPUTE = 1'b1;
  localparam logic MODE_NEAREST = 1'b0;

  // one-hot sequencer states
  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_POS  = 7'b0000010,
    ST_IDX  = 7'b0000100,
    ST_RD   = 7'b0001000,
    ST_MUL  = 7'b0010000,
    ST_ACC  = 7'b0100000,
    ST_OUT  = 7'b1000000
  } state_t;

endpackage

@@ hdl/image_resample_nn_bilinear.sv @@
// ----------------------------------------------------------------------------
// image_resample_nn_bilinear - nearest / bilinear resampler over an image memory
// ----------------------------------------------------------------------------
// sequence: a write is stored at its accept edge; a compute word steps through POS, IDX, then
//   RD, MUL, ACC per tap (four taps bilinear, one nearest) and OUT; a bad channel goes IDX to OUT
// accept: no new word is taken until the result is loaded into the output register, as the taps
//   read one by one through the single read port of the memory; writes every cycle while idle
// reset: synchronous active-low rst_n idles the sequencer, drops out_valid and loads the
//   register reset values; image contents stay undefined until written, no clearing pass
// ----------------------------------------------------------------------------
module image_resample_nn_bilinear
  import irs_pkg::*;
#(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256,
  parameter int CHANNELS   = 3
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                in_operation,
  input  logic [11:0]         in_col,
  input  logic [11:0]         in_row,
  input  logic [1:0]          in_channel,
  input  logic [7:0]          in_pixel_in,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [7:0]          out_pixel_out,
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data
);

  localparam int XW    = $clog2(MAX_WIDTH);
  localparam int YW    = $clog2(MAX_HEIGHT);
  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT * CHANNELS;
  localparam int AW    = $clog2(DEPTH);

  // configuration
  logic                mode_r;
  logic [8:0]          src_width_r, src_height_r;
  logic [25:0]         x_step_r, y_step_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r       <= 1'b1;
      src_width_r  <= 9'd256;
      src_height_r <= 9'd256;
      x_step_r     <= 26'd65536;
      y_step_r     <= 26'd65536;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MODE:       mode_r       <= cfg_data[0];
        REG_SRC_WIDTH:  src_width_r  <= cfg_data[8:0];
        REG_SRC_HEIGHT: src_height_r <= cfg_data[8:0];
        REG_X_STEP:     x_step_r     <= cfg_data;
        REG_Y_STEP:     y_step_r     <= cfg_data;
        default: ;
      endcase
    end
  end

  // effective sizes: zero acts as one, oversize acts as max
  logic [12:0] w_eff, h_eff;
  always_comb begin
    w_eff = {4'd0, src_width_r};
    if (src_width_r == 9'd0) w_eff = 13'd1;
    else if ({4'd0, src_width_r} > 13'(MAX_WIDTH)) w_eff = 13'(MAX_WIDTH);
    h_eff = {4'd0, src_height_r};
    if (src_height_r == 9'd0) h_eff = 13'd1;
    else if ({4'd0, src_height_r} > 13'(MAX_HEIGHT)) h_eff = 13'(MAX_HEIGHT);
  end

  // image memory, one write port and one registered read port
  logic [7:0]    mem [DEPTH];
  logic          mem_we;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [7:0]    mem_rdata_r;

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= in_pixel_in;
    mem_rdata_r <= mem[mem_raddr];
  end

  state_t state_r, state_nxt;

  logic        in_fire;
  logic        out_load;
  // a waiting result only holds the sequencer in its last state
  assign in_ready = (state_r == ST_IDLE);
  assign in_fire  = in_valid && in_ready;

  assign mem_we = in_fire && (in_operation == OP_WRITE) &&
                  ({20'd0, in_col} < 32'(MAX_WIDTH)) &&
                  ({20'd0, in_row} < 32'(MAX_HEIGHT)) &&
                  ({30'd0, in_channel} < 32'(CHANNELS));
  assign mem_waddr = AW'((32'(in_row) * MAX_WIDTH + 32'(in_col)) * CHANNELS
                         + 32'(in_channel));

  // per-item registers
  logic [11:0] col_r, row_r;
  logic [1:0]  ch_r;
  logic        bad_ch_r;
  logic [38:0] px_r, py_r;      // position plus one, Q.16
  logic [XW-1:0] x0_r, x1_r;
  logic [YW-1:0] y0_r, y1_r;
  logic [16:0] fx_r, fy_r, gx_r, gy_r;
  logic [1:0]  tap_r;
  logic [33:0] wgt_r;           // weight of current tap, up to 2^32
  logic [41:0] rnd_sum;
  logic [41:0] acc_r;
  logic [7:0]  pix_r;
  logic        out_valid_r;

  // index clamp: v is floor(pos)+1 offset, real index v - off
  function automatic logic [12:0] clampi(input logic [22:0] v, input logic off,
                                         input logic [12:0] size);
    logic [23:0] s;
    begin
      s = {1'b0, v} - {23'd0, off};
      if (s[23]) clampi = 13'd0;
      else if (s >= {11'd0, size}) clampi = size - 13'd1;
      else clampi = s[12:0];
    end
  endfunction

  logic [38:0] pxn, pyn;
  assign pxn = px_r - 39'd32768;
  assign pyn = py_r - 39'd32768;

  logic [12:0] xa, xb, ya, yb;
  always_comb begin
    if (mode_r == MODE_NEAREST) begin
      xa = clampi(pxn[38:16], 1'b0, w_eff);
      ya = clampi(pyn[38:16], 1'b0, h_eff);
      xb = xa;
      yb = ya;
    end else begin
      xa = clampi(px_r[38:16], 1'b1, w_eff);
      xb = clampi(px_r[38:16], 1'b0, w_eff);
      ya = clampi(py_r[38:16], 1'b1, h_eff);
      yb = clampi(py_r[38:16], 1'b0, h_eff);
    end
  end

  // tap select
  logic [XW-1:0] tx;
  logic [YW-1:0] ty;
  logic [16:0]   wa, wb;
  always_comb begin
    tx = tap_r[0] ? x1_r : x0_r;
    ty = tap_r[1] ? y1_r : y0_r;
    wa = tap_r[0] ? fx_r : gx_r;
    wb = tap_r[1] ? fy_r : gy_r;
  end
  assign mem_raddr = AW'((32'(ty) * MAX_WIDTH + 32'(tx)) * CHANNELS + 32'(ch_r));

  logic last_tap;
  assign last_tap = (mode_r == MODE_NEAREST) || (tap_r == 2'd3);

  // result register free or being emptied this cycle
  assign out_load = (state_r == ST_OUT) && (!out_valid_r || out_ready);

  // round to nearest on the Q32 sum
  assign rnd_sum = acc_r + 42'h0_8000_0000;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (in_fire && in_operation == OP_COMPUTE) state_nxt = ST_POS;
      ST_POS:  state_nxt = ST_IDX;
      ST_IDX:  state_nxt = bad_ch_r ? ST_OUT : ST_RD;
      ST_RD:   state_nxt = ST_MUL;
      ST_MUL:  state_nxt = ST_ACC;
      ST_ACC:  state_nxt = last_tap ? ST_OUT : ST_RD;
      ST_OUT:  state_nxt = out_load ? ST_IDLE : ST_OUT;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_load) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        col_r    <= in_col;
        row_r    <= in_row;
        ch_r     <= in_channel;
        bad_ch_r <= ({30'd0, in_channel} >= 32'(CHANNELS));
      end
      ST_POS: begin
        // 26x12 products, one per axis
        px_r <= 39'(x_step_r * col_r) + 39'(x_step_r >> 1) + 39'd32768;
        py_r <= 39'(y_step_r * row_r) + 39'(y_step_r >> 1) + 39'd32768;
      end
      ST_IDX: begin
        x0_r  <= XW'(xa);
        x1_r  <= XW'(xb);
        y0_r  <= YW'(ya);
        y1_r  <= YW'(yb);
        fx_r  <= {1'b0, px_r[15:0]};
        fy_r  <= {1'b0, py_r[15:0]};
        gx_r  <= 17'd65536 - {1'b0, px_r[15:0]};
        gy_r  <= 17'd65536 - {1'b0, py_r[15:0]};
        tap_r <= 2'd0;
        acc_r <= 42'd0;
      end
      ST_RD: wgt_r <= 34'(wa * wb);
      ST_MUL: ;
      ST_ACC: begin
        acc_r <= acc_r + 42'(wgt_r * mem_rdata_r);
        tap_r <= tap_r + 2'd1;
      end
      ST_OUT: begin
        if (out_load) begin
          if (bad_ch_r) pix_r <= 8'd0;
          else if (mode_r == MODE_NEAREST) pix_r <= mem_rdata_r;
          else pix_r <= (rnd_sum[41:32] > 10'd255) ? 8'd255 : rnd_sum[39:32];
        end
      end
      default: ;
    endcase
  end

  assign out_valid     = out_valid_r;
  assign out_pixel_out = pix_r;

`ifndef SYNTHESIS
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> !in_ready) else $error("accept while busy");
  a_out_from_seq: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(state_r == ST_OUT)) else $error("stray result");
  a_no_write_busy: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (state_r == ST_IDLE)) else $error("write while busy");
`endif

endmodule

@@ tb/sv/irs_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irs_checker - result predictor and scoreboard for the image resampler
// ----------------------------------------------------------------------------
// Mirrors the image memory and the settings registers. Every accepted compute
// word pushes its expected pixel. Every accepted result word is compared with
// the oldest expected pixel.
// ----------------------------------------------------------------------------
module irs_checker
  import irs_pkg::*;
#(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256,
  parameter int CHANNELS   = 3
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_ready,
  input  logic                in_operation,
  input  logic [11:0]         in_col,
  input  logic [11:0]         in_row,
  input  logic [1:0]          in_channel,
  input  logic [7:0]          in_pixel_in,
  input  logic                out_valid,
  input  logic                out_ready,
  input  logic [7:0]          out_pixel_out,
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data,
  output int                  fail_count,
  output int                  pending
);

  logic [7:0]  image_mem [0:MAX_WIDTH*MAX_HEIGHT*CHANNELS-1];
  logic        mode_q;
  logic [8:0]  width_q;
  logic [8:0]  height_q;
  logic [25:0] xstep_q;
  logic [25:0] ystep_q;
  logic [7:0]  expected_pix [$];
  logic [7:0]  want;

  function automatic longint unsigned eff_dim(logic [8:0] s, int maxv);
    if (s == 0) return 1;
    if (s > maxv) return maxv;
    return s;
  endfunction

  // source position plus one, q.16, never negative
  function automatic longint unsigned src_pos1(logic [25:0] step, logic [11:0] idx);
    longint unsigned st;
    st = step;
    return st * idx + (st >> 1) + 64'd32768;
  endfunction

  function automatic longint unsigned clamp_idx(longint v, longint unsigned size);
    if (v < 0) return 0;
    if (longint'(size) <= v) return size - 1;
    return v;
  endfunction

  function automatic longint unsigned tap(longint unsigned x, longint unsigned y,
                                          logic [1:0] ch);
    return image_mem[(y * MAX_WIDTH + x) * CHANNELS + ch];
  endfunction

  function automatic logic [7:0] resample(logic [11:0] col, logic [11:0] row,
                                          logic [1:0] ch);
    longint unsigned w, h, px, py, fx, fy, gx, gy, acc, x0, x1, y0, y1;
    longint xf, yf;
    if (ch >= CHANNELS) return 8'd0;
    w  = eff_dim(width_q, MAX_WIDTH);
    h  = eff_dim(height_q, MAX_HEIGHT);
    px = src_pos1(xstep_q, col);
    py = src_pos1(ystep_q, row);
    if (mode_q == MODE_NEAREST) begin
      x0 = clamp_idx(longint'((px - 32768) >> 16), w);
      y0 = clamp_idx(longint'((py - 32768) >> 16), h);
      return 8'(tap(x0, y0, ch));
    end
    xf = longint'(px >> 16) - 1;
    yf = longint'(py >> 16) - 1;
    fx = px & 64'hFFFF;
    fy = py & 64'hFFFF;
    gx = 65536 - fx;
    gy = 65536 - fy;
    x0 = clamp_idx(xf, w);
    x1 = clamp_idx(xf + 1, w);
    y0 = clamp_idx(yf, h);
    y1 = clamp_idx(yf + 1, h);
    acc = gx * gy * tap(x0, y0, ch) + fx * gy * tap(x1, y0, ch)
        + gx * fy * tap(x0, y1, ch) + fx * fy * tap(x1, y1, ch);
    acc = (acc + 64'h8000_0000) >> 32;
    if (acc > 255) acc = 255;
    return 8'(acc);
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      mode_q   <= 1'b1;
      width_q  <= 9'd256;
      height_q <= 9'd256;
      xstep_q  <= 26'd65536;
      ystep_q  <= 26'd65536;
      expected_pix.delete();
      fail_count = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          REG_MODE:       mode_q   <= cfg_data[0];
          REG_SRC_WIDTH:  width_q  <= cfg_data[8:0];
          REG_SRC_HEIGHT: height_q <= cfg_data[8:0];
          REG_X_STEP:     xstep_q  <= cfg_data[25:0];
          REG_Y_STEP:     ystep_q  <= cfg_data[25:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        if (in_operation == OP_WRITE) begin
          if (in_col < MAX_WIDTH && in_row < MAX_HEIGHT && in_channel < CHANNELS)
            image_mem[(in_row * MAX_WIDTH + in_col) * CHANNELS + in_channel] = in_pixel_in;
        end else begin
          expected_pix.push_back(resample(in_col, in_row, in_channel));
        end
      end
      if (out_valid && out_ready) begin
        if (expected_pix.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected pixel_out word, actual %0d", $time, out_pixel_out);
        end else begin
          want = expected_pix.pop_front();
          if (out_pixel_out !== want) begin
            fail_count++;
            $display("%0t: pixel_out mismatch, expected %0d actual %0d",
                     $time, want, out_pixel_out);
          end
        end
      end
    end
    pending = expected_pix.size();
  end

endmodule

@@ tb/sv/tb_image_resample_nn_bilinear.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_image_resample_nn_bilinear - stimulus and verdict for the image resampler
// ----------------------------------------------------------------------------
// Runs a set of settings phases (nearest and bilinear, tiny to full-width
// images, zero and extreme steps). Before computes in a phase, every source
// entry that the clamped taps can reach is written, so no compute reads an
// unwritten entry. Results are checked by irs_checker.
// ----------------------------------------------------------------------------
module tb_image_resample_nn_bilinear;
  import irs_pkg::*;

  localparam int MAX_W      = 256;
  localparam int MAX_H      = 256;
  localparam int NCH        = 3;
  localparam int CYCLE_CAP  = 1000000;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  logic                in_operation;
  logic [11:0]         in_col;
  logic [11:0]         in_row;
  logic [1:0]          in_channel;
  logic [7:0]          in_pixel_in;
  logic                out_valid;
  logic                out_ready;
  logic [7:0]          out_pixel_out;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_index;
  logic [CfgDataW-1:0] cfg_data;
  int                  fail_count;
  int                  pending;

  bit written [0:MAX_W*MAX_H*NCH-1];   // entries already stored in the image
  bit quiet;                           // no idling on either side
  bit hold_req;                        // ask the receiver for one long hold-off
  int cycles;

  image_resample_nn_bilinear #(.MAX_WIDTH(MAX_W), .MAX_HEIGHT(MAX_H), .CHANNELS(NCH))
    u_dut (.*);

  irs_checker #(.MAX_WIDTH(MAX_W), .MAX_HEIGHT(MAX_H), .CHANNELS(NCH))
    u_chk (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_CAP) begin
      $display("** image_resample_nn_bilinear: FAILED **");
      $finish;
    end
  end

  // receiver: short random stalls, one long hold-off on request
  initial begin
    bit hold_done;
    hold_done = 0;
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        hold_done = 1;
        out_ready <= 1'b0;
        repeat (200) @(posedge clk);
        out_ready <= 1'b1;
      end else if (!quiet && $urandom_range(0, 4) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // one word on the input channel; valid stays up unless an idle burst follows
  task automatic send_word(logic op, logic [11:0] col, logic [11:0] row,
                           logic [1:0] ch, logic [7:0] pix);
    in_valid     <= 1'b1;
    in_operation <= op;
    in_col       <= col;
    in_row       <= row;
    in_channel   <= ch;
    in_pixel_in  <= pix;
    do @(posedge clk); while (!in_ready);
    if (op == OP_WRITE && col < MAX_W && row < MAX_H && ch < NCH)
      written[(row * MAX_W + col) * NCH + ch] = 1;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  // sender pauses until every expected pixel is back and the block is idle
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (20) @(posedge clk);
  endtask

  function automatic int eff_dim(int s, int maxv);
    if (s == 0) return 1;
    if (s > maxv) return maxv;
    return s;
  endfunction

  // lowest source index that index 0 can touch
  function automatic int reach_lo(logic [25:0] s, int e);
    longint unsigned p;
    p = ({38'd0, s} >> 1) + 64'd32768;
    if ((p >> 16) == 0) return 0;
    if ((p >> 16) - 1 >= e) return e - 1;
    return int'((p >> 16) - 1);
  endfunction

  // highest source index that index 4095 can touch
  function automatic int reach_hi(logic [25:0] s, int e);
    longint unsigned p;
    p = {38'd0, s} * 64'd4095 + ({38'd0, s} >> 1) + 64'd32768;
    if ((p >> 16) >= e) return e - 1;
    return int'(p >> 16);
  endfunction

  // program all five registers, then fill whatever the clamped taps can reach
  task automatic setup_phase(logic m, int w, int h, logic [25:0] xs, logic [25:0] ys);
    int ew, eh, xlo, xhi, ylo, yhi;
    drain();
    cfg_we <= 1'b1;
    cfg_index <= REG_MODE;       cfg_data <= CfgDataW'(m);  @(posedge clk);
    cfg_index <= REG_SRC_WIDTH;  cfg_data <= CfgDataW'(w);  @(posedge clk);
    cfg_index <= REG_SRC_HEIGHT; cfg_data <= CfgDataW'(h);  @(posedge clk);
    cfg_index <= REG_X_STEP;     cfg_data <= xs;            @(posedge clk);
    cfg_index <= REG_Y_STEP;     cfg_data <= ys;            @(posedge clk);
    cfg_we <= 1'b0;
    ew  = eff_dim(w, MAX_W);
    eh  = eff_dim(h, MAX_H);
    xlo = reach_lo(xs, ew);
    xhi = reach_hi(xs, ew);
    ylo = reach_lo(ys, eh);
    yhi = reach_hi(ys, eh);
    for (int y = ylo; y <= yhi; y++)
      for (int x = xlo; x <= xhi; x++)
        for (int c = 0; c < NCH; c++)
          if (!written[(y * MAX_W + x) * NCH + c])
            send_word(OP_WRITE, 12'(x), 12'(y), 2'(c), 8'($urandom_range(0, 255)));
  endtask

  function automatic logic [25:0] rand_step();
    case ($urandom_range(0, 5))
      0:       return 26'(0);
      1:       return 26'($urandom);
      2:       return 26'd65536;
      default: return 26'($urandom_range(1, 131071));
    endcase
  endfunction

  // random words: mostly computes, some writes (in range or ignored ones)
  task automatic random_words(int n, int w, int h);
    logic [11:0] col, row;
    int ew, eh;
    ew = eff_dim(w, MAX_W);
    eh = eff_dim(h, MAX_H);
    for (int i = 0; i < n; i++) begin
      col = ($urandom_range(0, 3) == 0) ? 12'($urandom) : 12'($urandom_range(0, 40));
      row = ($urandom_range(0, 3) == 0) ? 12'($urandom) : 12'($urandom_range(0, 40));
      case ($urandom_range(0, 9))
        0:       send_word(OP_WRITE, 12'($urandom_range(0, ew - 1)),
                           12'($urandom_range(0, eh - 1)), 2'($urandom_range(0, 2)),
                           8'($urandom));
        1:       send_word(OP_WRITE, col, row, 2'($urandom), 8'($urandom));
        default: send_word(OP_COMPUTE, col, row,
                           ($urandom_range(0, 9) == 0) ? 2'd3 : 2'($urandom_range(0, 2)),
                           8'($urandom));
      endcase
    end
  endtask

  initial begin
    int w, h;
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_operation = OP_WRITE;
    in_col       = '0;
    in_row       = '0;
    in_channel   = '0;
    in_pixel_in  = '0;
    cfg_we       = 1'b0;
    cfg_index    = REG_MODE;
    cfg_data     = '0;
    quiet        = 0;
    hold_req     = 0;
    cycles       = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: nearest, 4x4, unit step
    setup_phase(MODE_NEAREST, 4, 4, 26'd65536, 26'd65536);
    send_word(OP_WRITE, 12'd0, 12'd0, 2'd0, 8'd255);
    send_word(OP_WRITE, 12'd3, 12'd3, 2'd2, 8'd0);
    send_word(OP_WRITE, 12'd4095, 12'd0, 2'd0, 8'd255);   // column out of range
    send_word(OP_WRITE, 12'd0, 12'd4095, 2'd1, 8'd255);   // row out of range
    send_word(OP_WRITE, 12'd1, 12'd1, 2'd3, 8'd255);      // bad channel
    send_word(OP_COMPUTE, 12'd0, 12'd0, 2'd0, 8'd0);
    send_word(OP_COMPUTE, 12'd3, 12'd3, 2'd2, 8'd255);
    send_word(OP_COMPUTE, 12'd4095, 12'd4095, 2'd1, 8'd0);
    send_word(OP_COMPUTE, 12'd2, 12'd1, 2'd3, 8'd0);      // bad channel gives zero

    // directed: bilinear upscale by two, weights at quarter and three-quarter positions
    setup_phase(1'b1, 4, 4, 26'd32768, 26'd32768);
    for (int i = 0; i < 6; i++)
      send_word(OP_COMPUTE, 12'(i), 12'(5 - i), 2'(i % 3), 8'd0);
    send_word(OP_COMPUTE, 12'd4095, 12'd0, 2'd0, 8'd0);

    // directed: step extremes over one full-width row
    setup_phase(1'b1, 256, 1, 26'h3FF_FFFF, 26'd1);
    send_word(OP_COMPUTE, 12'd0, 12'd0, 2'd0, 8'd0);
    send_word(OP_COMPUTE, 12'd1, 12'd4095, 2'd1, 8'd0);
    send_word(OP_COMPUTE, 12'd4095, 12'd4095, 2'd2, 8'd0);
    random_words(30, 256, 1);

    // oversize width, nearest
    setup_phase(MODE_NEAREST, 511, 1, 26'd1, 26'h3FF_FFFF);
    random_words(30, 511, 1);

    // zero width acts as one, oversize height
    setup_phase(1'b1, 0, 300, 26'd1, 26'd300);
    random_words(30, 0, 300);

    // zero steps map everything to the corner
    setup_phase(MODE_NEAREST, 1, 1, 26'd0, 26'd0);
    random_words(15, 1, 1);

    // random phases; one with a long receiver hold-off
    for (int p = 0; p < 8; p++) begin
      w = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 12);
      h = $urandom_range(1, 12);
      setup_phase(1'($urandom), w, h, rand_step(), rand_step());
      if (p == 2) hold_req = 1;
      if (p == 7) quiet = 1;
      random_words(35, w, h);
    end

    drain();
    if (fail_count == 0)
      $display("** image_resample_nn_bilinear: PASSED **");
    else
      $display("** image_resample_nn_bilinear: FAILED **");
    $finish;
  end

endmodule
